[hw/rtl/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, codes and constants of the console bus decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

	// Bus access kinds
	typedef enum logic [1:0] {
		REQ_MEM_RD = 2'd0,
		REQ_MEM_WR = 2'd1,
		REQ_IO_RD  = 2'd2,
		REQ_IO_WR  = 2'd3
	} cbd_req_t;

	// Decoded destination of an access
	typedef enum logic [2:0] {
		TGT_NONE     = 3'd0,
		TGT_BIOS     = 3'd1,
		TGT_RAM      = 3'd2,
		TGT_CART     = 3'd3,
		TGT_VDP_DATA = 3'd4,
		TGT_VDP_CTRL = 3'd5,
		TGT_PSG      = 3'd6,
		TGT_CTRL     = 3'd7
	} cbd_target_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_BIOS_PRESENT = 2'd0,
		CFG_BIOS_MASK    = 2'd1,
		CFG_CART_PRESENT = 2'd2,
		CFG_CART_MASK    = 2'd3
	} cbd_cfg_idx_t;

	// Memory map
	localparam logic [15:0] BIOS_HI = 16'h1fff;
	localparam logic [15:0] RAM_LO  = 16'h6000;
	localparam logic [15:0] RAM_HI  = 16'h7fff;
	localparam logic [15:0] CART_LO = 16'h8000;

	// I/O port ranges
	localparam logic [7:0] PORT_KPAD_LO = 8'h80;
	localparam logic [7:0] PORT_VDP_LO  = 8'ha0;
	localparam logic [7:0] PORT_VDP_HI  = 8'hbf;
	localparam logic [7:0] PORT_JOY_LO  = 8'hc0;
	localparam logic [7:0] PORT_CTRL_LO = 8'he0;

	localparam logic [7:0] OPEN_BUS = 8'hff;

	// Reset values of the configuration registers
	localparam logic [12:0] BIOS_MASK_RST = 13'h1fff;
	localparam logic [15:0] CART_MASK_RST = 16'h7fff;

	// RAM window size (mirror span) and default RAM size
	localparam int RAM_SPAN      = 8192;
	localparam int RAM_IDX_W     = 13;
	localparam int RAM_BYTES_DEF = 1024;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// One decoded access as it travels from front to back
	typedef struct packed {
		logic                 is_ram_rd;
		logic                 is_ram_wr;
		logic [RAM_IDX_W-1:0] ram_idx;
		logic [7:0]           wdata;
		logic [7:0]           read_data;
		cbd_target_t          target;
		logic [15:0]          dev_addr;
		logic [7:0]           fwd_data;
		logic                 kpad_mode;
	} cbd_op_t;

	// Queue fill status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} cbd_qstat_t;

	// Active-low keypad code for a key index; undefined indexes read as no key
	function automatic logic [3:0] key_code(input logic [3:0] key);
		logic [3:0] code;
		unique case (key)
			4'd0:    code = 4'hf;
			4'd1:    code = 4'hd;
			4'd2:    code = 4'h7;
			4'd3:    code = 4'hc;
			4'd4:    code = 4'h2;
			4'd5:    code = 4'h3;
			4'd6:    code = 4'he;
			4'd7:    code = 4'h5;
			4'd8:    code = 4'h1;
			4'd9:    code = 4'hb;
			4'd10:   code = 4'ha;
			4'd11:   code = 4'h9;
			4'd12:   code = 4'h6;
			default: code = 4'hf;
		endcase
		return code;
	endfunction

endpackage

[hw/rtl/cbd_front.sv]
// ----------------------------------------------------------------------------
// cbd_front
// Accepts bus words, holds configuration and controller mode, and classifies
// each access into a decoded operation for the back end.
// ----------------------------------------------------------------------------
module cbd_front #(
	parameter int RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	// input word
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [15:0]         address,
	input  logic [7:0]          write_data,
	input  logic                joy_up,
	input  logic                joy_right,
	input  logic                joy_down,
	input  logic                joy_left,
	input  logic                fire_left,
	input  logic                fire_right,
	input  logic [3:0]          keypad_key,
	// queue side
	input  cbd_pkg::cbd_qstat_t qstat,
	output logic                push,
	output cbd_pkg::cbd_op_t    push_op
);

	// Restoring steps that fold a 13-bit window offset into the RAM size
	localparam int MOD_STEPS = $clog2((cbd_pkg::RAM_SPAN + RAM_BYTES - 1) / RAM_BYTES);

	logic        bios_present_q;
	logic [12:0] bios_mask_q;
	logic        cart_present_q;
	logic [15:0] cart_mask_q;
	logic        mode_q;
	logic        mode_next;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bios_present_q <= 1'b0;
			bios_mask_q    <= cbd_pkg::BIOS_MASK_RST;
			cart_present_q <= 1'b0;
			cart_mask_q    <= cbd_pkg::CART_MASK_RST;
		end else if (cfg_we) begin
			unique case (cbd_pkg::cbd_cfg_idx_t'(cfg_index))
				cbd_pkg::CFG_BIOS_PRESENT: bios_present_q <= cfg_data[0];
				cbd_pkg::CFG_BIOS_MASK:    bios_mask_q    <= cfg_data[12:0];
				cbd_pkg::CFG_CART_PRESENT: cart_present_q <= cfg_data[0];
				cbd_pkg::CFG_CART_MASK:    cart_mask_q    <= cfg_data;
				default:                   bios_present_q <= bios_present_q;
			endcase
		end
	end

	assign in_stall = qstat.full;
	assign push     = in_valid && !in_stall;

	// Decode one access
	always_comb begin
		logic [7:0]                     port;
		logic [cbd_pkg::RAM_IDX_W-1:0] rem;
		logic                           in_ram;
		logic [7:0]                     joy_byte;
		logic [7:0]                     kpad_byte;

		port   = address[7:0];
		in_ram = (address >= cbd_pkg::RAM_LO) && (address <= cbd_pkg::RAM_HI);

		// mirror the RAM window onto the fitted RAM size
		rem = address[cbd_pkg::RAM_IDX_W-1:0];
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (rem >= cbd_pkg::RAM_IDX_W'(RAM_BYTES << k))
				rem = rem - cbd_pkg::RAM_IDX_W'(RAM_BYTES << k);
		end

		joy_byte  = {1'b0, ~fire_left, 2'b11, ~joy_left, ~joy_down, ~joy_right, ~joy_up};
		kpad_byte = {1'b0, ~fire_right, 2'b11, cbd_pkg::key_code(keypad_key)};

		mode_next         = mode_q;
		push_op.is_ram_rd = 1'b0;
		push_op.is_ram_wr = 1'b0;
		push_op.ram_idx   = rem;
		push_op.wdata     = write_data;
		push_op.read_data = cbd_pkg::OPEN_BUS;
		push_op.target    = cbd_pkg::TGT_NONE;
		push_op.dev_addr  = 16'h0000;
		push_op.fwd_data  = 8'h00;

		unique case (cbd_pkg::cbd_req_t'(req_type))
			cbd_pkg::REQ_MEM_RD: begin
				priority if (address <= cbd_pkg::BIOS_HI && bios_present_q) begin
					push_op.target   = cbd_pkg::TGT_BIOS;
					push_op.dev_addr = address & {3'b000, bios_mask_q};
				end else if (in_ram) begin
					push_op.target    = cbd_pkg::TGT_RAM;
					push_op.is_ram_rd = 1'b1;
				end else if (address >= cbd_pkg::CART_LO && cart_present_q) begin
					push_op.target   = cbd_pkg::TGT_CART;
					push_op.dev_addr = address & cart_mask_q;
				end else begin
					push_op.target = cbd_pkg::TGT_NONE;
				end
			end
			cbd_pkg::REQ_MEM_WR: begin
				if (in_ram) begin
					push_op.target    = cbd_pkg::TGT_RAM;
					push_op.is_ram_wr = 1'b1;
				end
			end
			cbd_pkg::REQ_IO_RD: begin
				priority if (port >= cbd_pkg::PORT_VDP_LO && port <= cbd_pkg::PORT_VDP_HI) begin
					push_op.target = port[0] ? cbd_pkg::TGT_VDP_CTRL : cbd_pkg::TGT_VDP_DATA;
				end else if (port >= cbd_pkg::PORT_CTRL_LO) begin
					push_op.target = cbd_pkg::TGT_CTRL;
					// player two reads as open bus
					if (!port[1])
						push_op.read_data = mode_q ? kpad_byte : joy_byte;
				end else begin
					push_op.target = cbd_pkg::TGT_NONE;
				end
			end
			cbd_pkg::REQ_IO_WR: begin
				priority if (port >= cbd_pkg::PORT_CTRL_LO) begin
					push_op.target   = cbd_pkg::TGT_PSG;
					push_op.fwd_data = write_data;
				end else if (port >= cbd_pkg::PORT_JOY_LO) begin
					push_op.target = cbd_pkg::TGT_CTRL;
					mode_next      = 1'b0;
				end else if (port >= cbd_pkg::PORT_VDP_LO) begin
					push_op.target   = port[0] ? cbd_pkg::TGT_VDP_CTRL : cbd_pkg::TGT_VDP_DATA;
					push_op.fwd_data = write_data;
				end else if (port >= cbd_pkg::PORT_KPAD_LO) begin
					push_op.target = cbd_pkg::TGT_CTRL;
					mode_next      = 1'b1;
				end else begin
					push_op.target = cbd_pkg::TGT_NONE;
				end
			end
			default: push_op.target = cbd_pkg::TGT_NONE;
		endcase

		push_op.kpad_mode = mode_next;
	end

	// Controller mode latch, updated in access order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (push) begin
			mode_q <= mode_next;
		end
	end

endmodule

[hw/rtl/cbd_queue.sv]
// ----------------------------------------------------------------------------
// cbd_queue
// Short first-in first-out queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module cbd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cbd_pkg::cbd_op_t    push_op,
	input  logic                pop,
	output cbd_pkg::cbd_op_t    pop_op,
	output cbd_pkg::cbd_qstat_t qstat
);

	localparam int DEPTH = cbd_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	cbd_pkg::cbd_op_t slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_op      = slot_q[rd_ptr_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_op;
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[hw/rtl/cbd_back.sv]
// ----------------------------------------------------------------------------
// cbd_back
// Carries out decoded operations: work RAM access and the result register.
// ----------------------------------------------------------------------------
module cbd_back #(
	parameter int RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cbd_pkg::cbd_qstat_t qstat,
	input  cbd_pkg::cbd_op_t    pop_op,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          read_data,
	output logic [2:0]          target,
	output logic [15:0]         device_address,
	output logic [7:0]          forward_data,
	output logic                keypad_mode
);

	localparam int AW = $clog2(RAM_BYTES);

	logic [7:0]       ram_mem [RAM_BYTES];
	logic [7:0]       ram_rd_q;
	cbd_pkg::cbd_op_t out_op_q;
	logic             out_valid_q;
	logic [AW-1:0]    idx;

	// Take the next word when the result register is free or being drained
	assign pop = !qstat.empty && (!out_valid_q || !out_stall);
	assign idx = pop_op.ram_idx[AW-1:0];

	// Work RAM: one access per popped word, read data registered
	always_ff @(posedge clk) begin
		if (pop) begin
			if (pop_op.is_ram_wr)
				ram_mem[idx] <= pop_op.wdata;
			ram_rd_q <= ram_mem[idx];
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop)
			out_op_q <= pop_op;
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = out_op_q.is_ram_rd ? ram_rd_q : out_op_q.read_data;
	assign target         = out_op_q.target;
	assign device_address = out_op_q.dev_addr;
	assign forward_data   = out_op_q.fwd_data;
	assign keypad_mode    = out_op_q.kpad_mode;

endmodule

[hw/rtl/console_bus_decoder_top.sv]
// ----------------------------------------------------------------------------
// console_bus_decoder_top
// Decodes processor bus accesses into ROM, work RAM, video, sound and
// controller selects, with the work RAM held inside.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one bus access per word:
//   request kind, address, write byte and the player one controls. Output
//   channel (out_valid / out_stall) returns one result word per access, in
//   order. The configuration port (cfg_we, cfg_index, cfg_data) sets ROM
//   presence and masks; write it only while no access is in flight.
//   An accepted word passes through a queue slot and then the result
//   register before it is offered on the output. Throughput is one word
//   per cycle while out_stall is low; the single-port work RAM serves one
//   access per popped word in the back end.
//   Reset clears the configuration to its defaults, selects joystick mode and
//   empties the two-entry queue and the result register. Work RAM contents
//   are undefined until written; there is no clearing pass after reset.
//   When the receiver stalls, the result word holds; the queue absorbs two
//   more words and then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module console_bus_decoder_top #(
	parameter int RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic        joy_up,
	input  logic        joy_right,
	input  logic        joy_down,
	input  logic        joy_left,
	input  logic        fire_left,
	input  logic        fire_right,
	input  logic [3:0]  keypad_key,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [2:0]  target,
	output logic [15:0] device_address,
	output logic [7:0]  forward_data,
	output logic        keypad_mode
);

	cbd_pkg::cbd_qstat_t qstat;
	cbd_pkg::cbd_op_t    push_op;
	cbd_pkg::cbd_op_t    pop_op;
	logic                push;
	logic                pop;

	cbd_front #(
		.RAM_BYTES(RAM_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.address    (address),
		.write_data (write_data),
		.joy_up     (joy_up),
		.joy_right  (joy_right),
		.joy_down   (joy_down),
		.joy_left   (joy_left),
		.fire_left  (fire_left),
		.fire_right (fire_right),
		.keypad_key (keypad_key),
		.qstat      (qstat),
		.push       (push),
		.push_op    (push_op)
	);

	cbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.qstat   (qstat)
	);

	cbd_back #(
		.RAM_BYTES(RAM_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.qstat          (qstat),
		.pop_op         (pop_op),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.target         (target),
		.device_address (device_address),
		.forward_data   (forward_data),
		.keypad_mode    (keypad_mode)
	);

	// Only RAM and controller results carry a read byte
	a_open_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && target != cbd_pkg::TGT_RAM && target != cbd_pkg::TGT_CTRL)
		|-> read_data == cbd_pkg::OPEN_BUS)
		else $error("read byte on a result that has none");

	// Only ROM results carry a device address
	a_dev_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && target != cbd_pkg::TGT_BIOS && target != cbd_pkg::TGT_CART)
		|-> device_address == 16'h0000)
		else $error("device address on a non-ROM result");

	// Only video and sound results forward a byte
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (target == cbd_pkg::TGT_NONE || target == cbd_pkg::TGT_BIOS ||
			target == cbd_pkg::TGT_RAM || target == cbd_pkg::TGT_CART ||
			target == cbd_pkg::TGT_CTRL))
		|-> forward_data == 8'h00)
		else $error("forward byte on a result that has none");

	// A full queue must hold off the input side
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.full && !pop) |=> in_stall)
		else $error("input not held off with the queue full");

endmodule
